// File: design/command_line_tokenizer_unit_defines.svh
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLTU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cltu_pkg.sv
package cltu_pkg;

  localparam int PEND_W = 5;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_BS,
    SEL_TAIL,
    SEL_TEND,
    SEL_LEND
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic bs_nz;
    logic bs_one;
    logic tail;
    logic tend;
    logic eol;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/cltu_ctrl.sv
module cltu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cltu_pkg::dp_status_t status,
  output cltu_pkg::dp_cmd_t    cmd
);
  import cltu_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drain the plan in order: backslashes, tail result, token end, line end.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_BS;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.bs_nz && !status.tail && !status.tend && !status.eol) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.bs_nz) begin
            cmd.sel  = SEL_BS;
            cmd.last = status.bs_one && !status.tail && !status.tend && !status.eol;
          end else if (status.tail) begin
            cmd.sel  = SEL_TAIL;
            cmd.last = !status.eol;
          end else if (status.tend) begin
            cmd.sel  = SEL_TEND;
            cmd.last = 1'b0;
          end else begin
            cmd.sel  = SEL_LEND;
            cmd.last = 1'b1;
          end
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/cltu_dp.sv
module cltu_dp #(
  parameter int MAX_PENDING_BACKSLASHES = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_char_in,
  input  logic                 in_end_of_line,
  input  cltu_pkg::dp_cmd_t    cmd,
  output cltu_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_dropped_backslash,
  output logic                 out_run_last
);
  import cltu_pkg::*;

  localparam logic [PEND_W-1:0] PendMax = PEND_W'(MAX_PENDING_BACKSLASHES);

  // Tokenizer state
  logic              iq_r, iq_nxt;
  logic              eq_r, eq_nxt;
  logic              te_r, te_nxt;
  logic              skip_r, skip_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              ovf_r, ovf_nxt;

  // Plan of results for the item at work
  logic [PEND_W-1:0] bs_left_r, bs_left_nxt;
  logic              tail_r, tail_nxt;
  logic [1:0]        tail_kind_r, tail_kind_nxt;
  logic [7:0]        tail_byte_r, tail_byte_nxt;
  logic              tend_r, tend_nxt;
  logic              eol_r, eol_nxt;
  logic              ovf_show_r, ovf_show_nxt;

  // Output register
  logic              ov_r, ov_nxt;
  logic [1:0]        ok_r, ok_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              od_r, od_nxt;
  logic              ol_r, ol_nxt;

  logic              ws, act, te_mid, te_end;
  logic [PEND_W-1:0] n_a;
  logic              iq_a, eq_a, te_a, skip_a, ovf_a;
  logic [PEND_W-1:0] pend_a;

  always_comb begin
    ws = (in_char_in == CH_SPACE) ||
         ((in_char_in >= CH_TAB) && (in_char_in <= CH_CR));
    act    = !(skip_r && ws);
    iq_a   = iq_r;
    eq_a   = eq_r;
    te_a   = te_r;
    skip_a = skip_r;
    pend_a = pend_r;
    ovf_a  = ovf_r;
    n_a    = '0;
    te_mid = te_r;
    tail_nxt      = 1'b0;
    tail_kind_nxt = KIND_BYTE;
    tail_byte_nxt = in_char_in;
    if (act) begin
      skip_a = 1'b0;
      if (in_char_in == CH_QUOTE) begin
        n_a    = pend_r >> 1;
        te_mid = te_r && (n_a == '0);
        te_a   = te_mid;
        if (!pend_r[0]) begin
          eq_a = iq_r && te_mid;
          iq_a = !iq_r;
        end else begin
          tail_nxt      = 1'b1;
          tail_byte_nxt = CH_QUOTE;
          te_a          = 1'b0;
        end
        pend_a = '0;
      end else if (in_char_in == CH_BACKSLASH) begin
        if (pend_r < PendMax) begin
          pend_a = pend_r + 1'b1;
        end else begin
          ovf_a = 1'b1;
        end
      end else begin
        n_a    = pend_r;
        pend_a = '0;
        tail_nxt = 1'b1;
        if (ws && !iq_r) begin
          tail_kind_nxt = KIND_TOKEN_END;
          tail_byte_nxt = '0;
          te_a          = 1'b1;
          eq_a          = 1'b0;
          skip_a        = 1'b1;
        end else begin
          te_a = 1'b0;
        end
      end
    end
    // Only one of the two backslash counts is nonzero.
    te_end = te_a && !(in_end_of_line && (pend_a != '0));
  end

  always_comb begin
    iq_nxt       = iq_r;
    eq_nxt       = eq_r;
    te_nxt       = te_r;
    skip_nxt     = skip_r;
    pend_nxt     = pend_r;
    ovf_nxt      = ovf_r;
    bs_left_nxt  = bs_left_r;
    tend_nxt     = tend_r;
    eol_nxt      = eol_r;
    ovf_show_nxt = ovf_show_r;
    ov_nxt       = ov_r && out_stall;
    ok_nxt       = ok_r;
    ob_nxt       = ob_r;
    od_nxt       = od_r;
    ol_nxt       = ol_r;
    if (cmd.load) begin
      ovf_show_nxt = ovf_a;
      eol_nxt      = in_end_of_line;
      tend_nxt     = in_end_of_line && (!te_end || iq_a || eq_a);
      bs_left_nxt  = in_end_of_line ? n_a + pend_a : n_a;
      if (in_end_of_line) begin
        iq_nxt   = 1'b0;
        eq_nxt   = 1'b0;
        te_nxt   = 1'b1;
        skip_nxt = 1'b1;
        pend_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        iq_nxt   = iq_a;
        eq_nxt   = eq_a;
        te_nxt   = te_a;
        skip_nxt = skip_a;
        pend_nxt = pend_a;
        ovf_nxt  = ovf_a;
      end
    end
    if (cmd.emit) begin
      ov_nxt = 1'b1;
      od_nxt = ovf_show_r;
      ol_nxt = cmd.last;
      case (cmd.sel)
        SEL_BS: begin
          ok_nxt      = KIND_BYTE;
          ob_nxt      = CH_BACKSLASH;
          bs_left_nxt = bs_left_r - 1'b1;
        end
        SEL_TAIL: begin
          ok_nxt = tail_kind_r;
          ob_nxt = tail_byte_r;
        end
        SEL_TEND: begin
          ok_nxt   = KIND_TOKEN_END;
          ob_nxt   = '0;
          tend_nxt = 1'b0;
        end
        SEL_LEND: begin
          ok_nxt  = KIND_LINE_END;
          ob_nxt  = '0;
          eol_nxt = 1'b0;
        end
        default: begin
          ok_nxt = KIND_LINE_END;
          ob_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r       <= 1'b0;
      eq_r       <= 1'b0;
      te_r       <= 1'b1;
      skip_r     <= 1'b1;
      pend_r     <= '0;
      ovf_r      <= 1'b0;
      bs_left_r  <= '0;
      tail_r     <= 1'b0;
      tend_r     <= 1'b0;
      eol_r      <= 1'b0;
      ovf_show_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      iq_r       <= iq_nxt;
      eq_r       <= eq_nxt;
      te_r       <= te_nxt;
      skip_r     <= skip_nxt;
      pend_r     <= pend_nxt;
      ovf_r      <= ovf_nxt;
      bs_left_r  <= bs_left_nxt;
      tend_r     <= tend_nxt;
      eol_r      <= eol_nxt;
      ovf_show_r <= ovf_show_nxt;
      ov_r       <= ov_nxt;
      if (cmd.load) begin
        tail_r <= tail_nxt;
      end else if (cmd.emit && (cmd.sel == SEL_TAIL)) begin
        tail_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tail_kind_r <= tail_kind_nxt;
      tail_byte_r <= tail_byte_nxt;
    end
    ok_r <= ok_nxt;
    ob_r <= ob_nxt;
    od_r <= od_nxt;
    ol_r <= ol_nxt;
  end

  assign status.bs_nz    = (bs_left_r != '0);
  assign status.bs_one   = (bs_left_r == PEND_W'(1));
  assign status.tail     = tail_r;
  assign status.tend     = tend_r;
  assign status.eol      = eol_r;
  assign status.out_free = !ov_r || !out_stall;

  assign out_valid             = ov_r;
  assign out_kind              = ok_r;
  assign out_byte              = ob_r;
  assign out_dropped_backslash = od_r;
  assign out_run_last          = ol_r;

endmodule

// File: design/command_line_tokenizer_unit.sv
// Command line tokenizer: splits a byte stream into arguments with the
// common argument quoting rules (backslash runs before a quote, quoted
// spaces, empty quote pairs as empty arguments).
// Input channel: in_valid / in_stall with in_char_in and in_end_of_line,
// one byte per item; in_end_of_line marks the last byte of a line.
// Result channel: out_valid / out_stall with out_kind (argument byte,
// token end, line end), out_byte, out_dropped_backslash and out_run_last,
// which flags the last result caused by an input byte.
// Timing: an item is taken while the block is idle, then its results leave
// one per cycle from the output register while the receiver does not stall;
// the block returns to accept in the cycle after the last result is loaded.
// A backslash or a skipped space without end of line gives no result. The
// single shared output register and the result-per-cycle emit loop keep the
// next item waiting until the last result of the current one is loaded.
// A stalled receiver holds the output register and freezes the emit loop.
// Reset (rst_n low, synchronous) clears quoting, the backslash count and
// the overflow flag and arms leading-whitespace skipping.
module command_line_tokenizer_unit #(
  parameter int MAX_PENDING_BACKSLASHES = 30
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_dropped_backslash,
  output logic       out_run_last
);
  import cltu_pkg::*;

  `include "command_line_tokenizer_unit_defines.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the results of one item.
  cltu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold tokenizer state, plan the results, drive the output register.
  cltu_dp #(
    .MAX_PENDING_BACKSLASHES (MAX_PENDING_BACKSLASHES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_char_in            (in_char_in),
    .in_end_of_line        (in_end_of_line),
    .cmd                   (cmd),
    .status                (status),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_byte              (out_byte),
    .out_dropped_backslash (out_dropped_backslash),
    .out_run_last          (out_run_last)
  );

  // A line end always closes the run of its item.
  `CLTU_ASSERT_NOW(a_line_end_last, out_valid && (out_kind == KIND_LINE_END), out_run_last, "line end not last")
  // Non-byte results carry a zero byte.
  `CLTU_ASSERT_NOW(a_zero_byte, out_valid && (out_kind != KIND_BYTE), out_byte == 8'd0, "nonzero byte on mark")
  // After a taken item the input is stalled in the next cycle.
  `CLTU_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken twice in a row")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cltu_pkg::*;

  // Backslash counter bound; the block gets the same value.
  localparam int BS_LIMIT = 30;
  // Random part: stop opening new lines once this many items went in.
  localparam int RANDOM_ITEMS = 400;
  // Report only the first few mismatches in full.
  localparam int SHOW_LIMIT = 10;

  typedef logic [7:0] byte_q_t[$];

  // One result of the splitter as seen on the out_ ports.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       dropped;
    logic       last;
  } arg_event_t;

  // Argument splitter predictor plus the store of events still owed by the block.
  class arg_event_board;
    arg_event_t        want_events[$];
    int unsigned       failures;
    logic              quoted;
    logic              empty_pair;
    logic              tok_empty;
    logic              skip_ws;
    logic              bs_lost;
    logic [PEND_W-1:0] bs_count;

    function new();
      failures = 0;
      clear_line();
    endfunction

    // Return every bit of line state to its reset value.
    function void clear_line();
      quoted     = 1'b0;
      empty_pair = 1'b0;
      tok_empty  = 1'b1;
      skip_ws    = 1'b1;
      bs_lost    = 1'b0;
      bs_count   = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void push_event(logic [1:0] kind, logic [7:0] ch);
      arg_event_t e;
      e.kind    = kind;
      e.ch      = ch;
      e.dropped = bs_lost;
      e.last    = 1'b0;
      want_events = {want_events, e};
    endfunction

    function void push_backslashes(int n);
      for (int i = 0; i < n; i++) push_event(KIND_BYTE, CH_BACKSLASH);
      if (n > 0) tok_empty = 1'b0;
    endfunction

    // Work out the events that one accepted item causes.
    function void note_byte(logic [7:0] c, logic eol);
      int unsigned first;
      arg_event_t  tail;
      bit          blank;
      first = want_events.size();
      blank = is_blank(c);
      if (!(skip_ws && blank)) begin
        skip_ws = 1'b0;
        if (c == CH_QUOTE) begin
          // Even run: half the backslashes, then toggle quoting.
          // Odd run: half rounded down, then a literal quote.
          push_backslashes(bs_count >> 1);
          if (!bs_count[0]) begin
            empty_pair = quoted && tok_empty;
            quoted     = !quoted;
          end else begin
            push_event(KIND_BYTE, CH_QUOTE);
            tok_empty = 1'b0;
          end
          bs_count = '0;
        end else if (c == CH_BACKSLASH) begin
          if (bs_count < BS_LIMIT) bs_count++;
          else bs_lost = 1'b1;
        end else begin
          push_backslashes(bs_count);
          bs_count = '0;
          if (blank && !quoted) begin
            push_event(KIND_TOKEN_END, 8'h00);
            tok_empty  = 1'b1;
            empty_pair = 1'b0;
            skip_ws    = 1'b1;
          end else begin
            push_event(KIND_BYTE, c);
            tok_empty = 1'b0;
          end
        end
      end
      if (eol) begin
        push_backslashes(bs_count);
        bs_count = '0;
        if (!tok_empty || quoted || empty_pair) push_event(KIND_TOKEN_END, 8'h00);
        push_event(KIND_LINE_END, 8'h00);
        clear_line();
      end
      // Flag the final event of this item.
      if (want_events.size() > first) begin
        tail      = want_events[want_events.size() - 1];
        tail.last = 1'b1;
        want_events[want_events.size() - 1] = tail;
      end
    endfunction

    // Compare one accepted result with the oldest owed event.
    function void check_event(arg_event_t got);
      arg_event_t want;
      if (want_events.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("mismatch: unowed result kind=%0d byte=%02h dropped=%0b last=%0b",
                   got.kind, got.ch, got.dropped, got.last);
        return;
      end
      want = want_events.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch ||
          got.dropped !== want.dropped || got.last !== want.last) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("mismatch: want kind=%0d byte=%02h dropped=%0b last=%0b, %s%0d %s%02h %s%0b %s%0b",
                   want.kind, want.ch, want.dropped, want.last,
                   "got kind=", got.kind, "byte=", got.ch,
                   "dropped=", got.dropped, "last=", got.last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_end_of_line;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_dropped_backslash;
  logic       out_run_last;

  arg_event_board board = new();

  int  items_sent = 0;
  // Burst modes: while set, that side does not idle at all.
  bit  in_calm    = 1'b0;
  bit  out_calm   = 1'b0;

  command_line_tokenizer_unit #(
    .MAX_PENDING_BACKSLASHES(BS_LIMIT)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_in           (in_char_in),
    .in_end_of_line       (in_end_of_line),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_byte             (out_byte),
    .out_dropped_backslash(out_dropped_backslash),
    .out_run_last         (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one item after a random gap; return at the edge that takes it.
  // Keep valid high without a dip when the next item follows at once.
  task automatic send_item(input logic [7:0] c, input logic eol);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_in     <= c;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(c, eol);
    items_sent++;
  endtask

  // Send a whole command line; mark its last byte as end of line.
  task automatic send_line(input byte_q_t text);
    for (int i = 0; i < text.size(); i++)
      send_item(text[i], i == text.size() - 1);
  endtask

  // Drop valid and hold the sender until every owed event has come out.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.want_events.size() != 0) @(posedge clk);
  endtask

  // Build a mostly well-formed line: words, blanks, quotes and backslash
  // runs, with a little raw noise. Optionally open with a run near the
  // backslash counter bound, long enough at times to saturate the counter.
  task automatic send_random_line(input bit long_run);
    byte_q_t    text;
    int         len;
    int         pick;
    int         run;
    logic [7:0] c;
    text = {};
    if (long_run) begin
      run = $urandom_range(BS_LIMIT - 2, BS_LIMIT + 4);
      repeat (run) text = {text, CH_BACKSLASH};
      if ($urandom_range(0, 1)) text = {text, CH_QUOTE};
    end
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        c = 8'($urandom_range(8'h61, 8'h7A));
        text = {text, c};
      end else if (pick < 45) begin
        run = $urandom_range(0, 5);
        c   = (run == 5) ? CH_SPACE : 8'(CH_TAB + run);
        text = {text, c};
      end else if (pick < 60) begin
        text = {text, CH_QUOTE};
      end else if (pick < 80) begin
        run = $urandom_range(1, 4);
        repeat (run) text = {text, CH_BACKSLASH};
      end else begin
        c = 8'($urandom_range(0, 255));
        text = {text, c};
      end
    end
    send_line(text);
  endtask

  // Result side: check each taken result, then stall for a drawn number
  // of cycles before taking the next one.
  initial begin
    arg_event_t got;
    int         hold;
    hold      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind    = out_kind;
        got.ch      = out_byte;
        got.dropped = out_dropped_backslash;
        got.last    = out_run_last;
        board.check_event(got);
        if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
        hold = out_calm ? 0 : $urandom_range(0, 19);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // Stimulus and end of run.
  initial begin
    int lines;
    lines          = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_char_in     <= 8'h00;
    in_end_of_line <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines.
    // Only whitespace: line end alone.
    send_line('{CH_SPACE});
    // All six blanks skipped up front, byte 0 and 0xFF as argument bytes,
    // then an empty quote pair closed by the end of line.
    send_line('{CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE, 8'h00, 8'hFF,
                CH_SPACE, CH_QUOTE, CH_QUOTE});
    // Even run before a quote, quoted space, odd run before a quote,
    // then a trailing backslash flushed by the end of line.
    send_line('{CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE, CH_SPACE, CH_BACKSLASH,
                CH_QUOTE, CH_QUOTE, CH_BACKSLASH});
    // Backslashes flushed by a plain byte; quote left open at end of line.
    send_line('{CH_BACKSLASH, CH_BACKSLASH, 8'h41, CH_QUOTE, 8'h7E});

    // Let everything settle before the random part.
    drain_events();

    // Random lines; the first one opens with a run near the backslash counter bound.
    while (items_sent < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 3) == 0);
      send_random_line(lines == 0 || $urandom_range(0, 11) == 0);
      lines++;
      if ($urandom_range(0, 9) == 0) drain_events();
    end

    drain_events();
    repeat (50) @(posedge clk);
    if (board.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
